### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clock and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UPI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UPI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/upi_pkg.sv
// ----------------------------------------------------------------------------
// Unicycle pose integrator package
// Widths, fixed-point constants, CORDIC table and shared types.
// ----------------------------------------------------------------------------
package upi_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int POS_BITS     = 32;

   localparam int CNT_W      = $clog2(CORDIC_STEPS);
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;

   localparam int HEAD_SHIFT = 61 - ANGLE_BITS;
   localparam int POS_SHIFT  = 38;
   localparam int POS_STEP_W = 64 - POS_SHIFT;
   localparam int SUM_W      = ((POS_BITS > POS_STEP_W) ? POS_BITS : POS_STEP_W) + 1;
   localparam int OUT_EXT_W  = (POS_BITS > 32) ? POS_BITS : 32;
   localparam int HEAD_EXT_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;

   localparam logic signed [63:0] HEAD_ROUND = 64'sd1 <<< (HEAD_SHIFT - 1);
   localparam logic signed [63:0] POS_ROUND  = 64'sd1 <<< (POS_SHIFT - 1);

   localparam logic signed [31:0] INV_PI_Q32   = 32'sd1367130551;
   localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;

   localparam logic [15:0] TICK_PERIOD_RESET = 16'd6554;

   // Arctangent of 2^-i as a 32-bit binary angle, rounded to nearest.
   localparam logic signed [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   function automatic logic signed [31:0] atan_of(input logic [CNT_W-1:0] idx);
      return ATAN_TURN32[ATAN_IDX_W'(idx)];
   endfunction

endpackage

### hw/rtl/upi_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one velocity command transaction per handshake.
// ----------------------------------------------------------------------------
interface upi_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_speed;
   logic signed [15:0] angular_speed;

   modport source (output valid, output linear_speed, output angular_speed, input ready);
   modport sink   (input valid, input linear_speed, input angular_speed, output ready);
endinterface

### hw/rtl/upi_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one pose transaction per handshake.
// ----------------------------------------------------------------------------
interface upi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] heading;

   modport source (output valid, output pos_x, output pos_y, output heading, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

### hw/rtl/upi_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries writes of the tick period register.
// ----------------------------------------------------------------------------
interface upi_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] tick_period;

   modport source (output valid, output tick_period, input ready);
   modport sink   (input valid, input tick_period, output ready);
endinterface

### hw/rtl/upi_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module upi_mul (
   input  logic                  clock,
   input  upi_pkg::mul_req_type  mul_req,
   output logic signed [63:0]    prod_ff
);

   logic signed [63:0] prod_in;

   assign prod_in = 64'(mul_req.a) * 64'(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hw/rtl/upi_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, giving Q30 cos and sin.
// ----------------------------------------------------------------------------
module upi_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  upi_pkg::cordic_ctl_type  ctl,
   output upi_pkg::cordic_sts_type  sts,
   output logic signed [31:0]       cos_q30,
   output logic signed [31:0]       sin_q30
);

   logic signed [31:0]          x_ff, x_in;
   logic signed [31:0]          y_ff, y_in;
   logic signed [31:0]          z_ff, z_in;
   logic [upi_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        half_turn;
   logic signed [31:0]          dx, dy, atan_i;

   // Angles in the left half-plane are turned by pi first.
   assign half_turn = ctl.angle[31] ^ ctl.angle[30];
   assign dx        = y_ff >>> cnt_ff;
   assign dy        = x_ff >>> cnt_ff;
   assign atan_i    = upi_pkg::atan_of(cnt_ff);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = half_turn ? -upi_pkg::CORDIC_K_Q30 : upi_pkg::CORDIC_K_Q30;
         y_in    = '0;
         z_in    = half_turn ? signed'({~ctl.angle[31], ctl.angle[30:0]})
                             : signed'(ctl.angle);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_i;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_i;
         end
         if (cnt_ff == upi_pkg::CNT_W'(upi_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign cos_q30  = x_ff;
   assign sin_q30  = y_ff;

endmodule

### hw/rtl/unicycle_pose_integrator_top.sv
// ----------------------------------------------------------------------------
// Unicycle pose integrator
// Euler-step odometry: heading, x and y advance once per velocity command.
// ----------------------------------------------------------------------------
// Each request transaction carries a forward speed and a turn rate and
// produces exactly one response transaction holding the updated pose. The
// block works on one request at a time: req_chan.ready is high only while
// the sequencer is idle, so a new request is not taken before the pose of
// the last one has been loaded into the response register. The work per
// request is done by the iterative CORDIC, which performs one micro-rotation
// per cycle, and by five passes through the single shared 32 x 32
// multiplier (turn rate times period, that times 1/pi, speed times period,
// and the two displacement products). The response register lets the next
// request be accepted while the previous pose still waits to be taken; if
// it is still waiting when the next pose is ready, the sequencer holds until
// it drains. The tick period register is written over csr_chan, which is
// always ready; writes are meant to happen while the block is idle.
// Positions saturate at the rails, and the heading wraps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unicycle_pose_integrator_top (
   input  logic   clock,
   input  logic   reset,
   upi_req_if.sink    req_chan,
   upi_rsp_if.source  rsp_chan,
   upi_csr_if.sink    csr_chan
);

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_MUL_WT   = 10'b00_0000_0010,
      S_MUL_HD   = 10'b00_0000_0100,
      S_HEAD     = 10'b00_0000_1000,
      S_CORD_GO  = 10'b00_0001_0000,
      S_CORD_RUN = 10'b00_0010_0000,
      S_MUL_X    = 10'b00_0100_0000,
      S_MUL_Y    = 10'b00_1000_0000,
      S_UPD_Y    = 10'b01_0000_0000,
      S_HOLD     = 10'b10_0000_0000
   } seq_state_type;

   seq_state_type seq_ff, seq_in;

   // Configuration and the accumulated pose.
   logic [15:0]                          tick_ff;
   logic [upi_pkg::ANGLE_BITS-1:0]       heading_acc_ff, heading_acc_in;
   logic signed [upi_pkg::POS_BITS-1:0]  x_acc_ff, x_acc_in;
   logic signed [upi_pkg::POS_BITS-1:0]  y_acc_ff, y_acc_in;

   // Latched command and the distance speed times period.
   logic signed [15:0]  lin_ff;
   logic signed [15:0]  ang_ff;
   logic signed [31:0]  travel_ff;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_x_ff;
   logic signed [31:0]  rsp_y_ff;
   logic signed [15:0]  rsp_head_ff;

   // Shared units.
   upi_pkg::mul_req_type     mul_req;
   logic signed [63:0]       prod_ff;
   upi_pkg::cordic_ctl_type  cord_ctl;
   upi_pkg::cordic_sts_type  cord_sts;
   logic signed [31:0]       cos_q30;
   logic signed [31:0]       sin_q30;

   logic                                  req_fire;
   logic                                  rsp_load;
   logic signed [63:0]                    head_sum;
   logic [upi_pkg::ANGLE_BITS-1:0]        head_delta;
   logic signed [63:0]                    pos_sum;
   logic signed [upi_pkg::POS_STEP_W-1:0] pos_step;
   logic signed [upi_pkg::POS_BITS-1:0]   x_next, y_next;

   // Adds a rounded displacement to a position and clamps to the rails.
   function automatic logic signed [upi_pkg::POS_BITS-1:0] add_clamp(
      input logic signed [upi_pkg::POS_BITS-1:0]   acc,
      input logic signed [upi_pkg::POS_STEP_W-1:0] stp
   );
      logic signed [upi_pkg::SUM_W-1:0] sum;
      logic signed [upi_pkg::SUM_W-1:0] hi;
      logic signed [upi_pkg::SUM_W-1:0] lo;
      sum = upi_pkg::SUM_W'(acc) + upi_pkg::SUM_W'(stp);
      hi  = upi_pkg::SUM_W'({1'b0, {(upi_pkg::POS_BITS - 1){1'b1}}});
      lo  = ~hi;
      if (sum > hi) begin
         return hi[upi_pkg::POS_BITS-1:0];
      end else if (sum < lo) begin
         return lo[upi_pkg::POS_BITS-1:0];
      end
      return sum[upi_pkg::POS_BITS-1:0];
   endfunction

   // Brings a position onto the 32-bit output, clamping when it is wider.
   function automatic logic signed [31:0] pos_to_out(
      input logic signed [upi_pkg::POS_BITS-1:0] pos
   );
      logic signed [upi_pkg::OUT_EXT_W-1:0] ext;
      logic signed [upi_pkg::OUT_EXT_W-1:0] hi;
      logic signed [upi_pkg::OUT_EXT_W-1:0] lo;
      ext = upi_pkg::OUT_EXT_W'(pos);
      hi  = upi_pkg::OUT_EXT_W'({1'b0, {31{1'b1}}});
      lo  = ~hi;
      if (ext > hi) begin
         return hi[31:0];
      end else if (ext < lo) begin
         return lo[31:0];
      end
      return ext[31:0];
   endfunction

   // Rescales the binary angle to 16 bits, keeping its top bits.
   function automatic logic signed [15:0] heading_to_out(
      input logic [upi_pkg::ANGLE_BITS-1:0] hd
   );
      logic [upi_pkg::HEAD_EXT_W-1:0] ext;
      ext = upi_pkg::HEAD_EXT_W'(hd) << (upi_pkg::HEAD_EXT_W - upi_pkg::ANGLE_BITS);
      return signed'(ext[upi_pkg::HEAD_EXT_W-1 -: 16]);
   endfunction

   upi_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   upi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cord_ctl),
      .sts     (cord_sts),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   assign req_chan.ready = (seq_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Heading step: rounded product of turn rate, period and 1/pi.
   assign head_sum   = prod_ff + upi_pkg::HEAD_ROUND;
   assign head_delta = head_sum[upi_pkg::HEAD_SHIFT +: upi_pkg::ANGLE_BITS];

   // Displacement: rounded product of distance and the Q30 cos or sin.
   assign pos_sum  = prod_ff + upi_pkg::POS_ROUND;
   assign pos_step = pos_sum[63 -: upi_pkg::POS_STEP_W];
   assign x_next   = add_clamp(x_acc_ff, pos_step);
   assign y_next   = add_clamp(y_acc_ff, pos_step);

   // The CORDIC starts from the already updated heading.
   assign cord_ctl.start = (seq_ff == S_CORD_GO);
   assign cord_ctl.angle = {heading_acc_ff, {(32 - upi_pkg::ANGLE_BITS){1'b0}}};

   assign rsp_load = (seq_ff == S_HOLD) && (!rsp_valid_ff || rsp_chan.ready);

   // Multiplier operand selection and the sequencer.
   always_comb begin
      mul_req        = '0;
      seq_in         = seq_ff;
      heading_acc_in = heading_acc_ff;
      x_acc_in       = x_acc_ff;
      y_acc_in       = y_acc_ff;
      unique case (seq_ff)
         S_IDLE: begin
            if (req_fire) begin
               seq_in = S_MUL_WT;
            end
         end
         S_MUL_WT: begin
            mul_req.a = 32'(ang_ff);
            mul_req.b = signed'({16'b0, tick_ff});
            seq_in    = S_MUL_HD;
         end
         S_MUL_HD: begin
            mul_req.a = prod_ff[31:0];
            mul_req.b = upi_pkg::INV_PI_Q32;
            seq_in    = S_HEAD;
         end
         S_HEAD: begin
            heading_acc_in = heading_acc_ff + head_delta;
            mul_req.a      = 32'(lin_ff);
            mul_req.b      = signed'({16'b0, tick_ff});
            seq_in         = S_CORD_GO;
         end
         S_CORD_GO: begin
            seq_in = S_CORD_RUN;
         end
         S_CORD_RUN: begin
            if (cord_sts.done) begin
               seq_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            mul_req.a = travel_ff;
            mul_req.b = cos_q30;
            seq_in    = S_MUL_Y;
         end
         S_MUL_Y: begin
            x_acc_in  = x_next;
            mul_req.a = travel_ff;
            mul_req.b = sin_q30;
            seq_in    = S_UPD_Y;
         end
         S_UPD_Y: begin
            y_acc_in = y_next;
            seq_in   = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_load) begin
               seq_in = S_IDLE;
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= S_IDLE;
         tick_ff        <= upi_pkg::TICK_PERIOD_RESET;
         heading_acc_ff <= '0;
         x_acc_ff       <= '0;
         y_acc_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seq_ff         <= seq_in;
         heading_acc_ff <= heading_acc_in;
         x_acc_ff       <= x_acc_in;
         y_acc_ff       <= y_acc_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_chan.valid) begin
            tick_ff <= csr_chan.tick_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         lin_ff <= req_chan.linear_speed;
         ang_ff <= req_chan.angular_speed;
      end
      // The speed-times-period product lands in the multiplier register here.
      if (seq_ff == S_CORD_GO) begin
         travel_ff <= prod_ff[31:0];
      end
      if (rsp_load) begin
         rsp_x_ff    <= pos_to_out(x_acc_ff);
         rsp_y_ff    <= pos_to_out(y_acc_ff);
         rsp_head_ff <= heading_to_out(heading_acc_ff);
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pos_x   = rsp_x_ff;
   assign rsp_chan.pos_y   = rsp_y_ff;
   assign rsp_chan.heading = rsp_head_ff;

   // A new request is only taken while the CORDIC is at rest.
   `UPI_ASSERT_SAME(a_ready_cordic_idle, req_chan.ready, !cord_sts.busy,
      "request accepted while CORDIC busy")

   // The CORDIC only reports completion while the sequencer waits for it.
   `UPI_ASSERT_SAME(a_done_in_run, cord_sts.done, seq_ff == S_CORD_RUN,
      "CORDIC completion outside its wait state")

   // The heading only moves in the heading update state.
   `UPI_ASSERT_NEXT(a_heading_hold, seq_ff != S_HEAD, $stable(heading_acc_ff),
      "heading changed outside its update state")

endmodule

### dv/upi_pose_checker.sv
// ----------------------------------------------------------------------------
// Pose integrator checker
// Watches the command, pose and tick period channels. Predicts every pose
// from the accepted commands and compares it with the pose the block returns.
// ----------------------------------------------------------------------------
module upi_pose_checker (
   input  logic clock,
   input  logic reset,
   upi_req_if   req_mon,
   upi_rsp_if   rsp_mon,
   upi_csr_if   csr_mon,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
   } pose_type;

   pose_type                       pending_poses [$];
   logic [15:0]                    period_q;
   logic [upi_pkg::ANGLE_BITS-1:0] heading_q;
   longint                         x_q;
   longint                         y_q;

   function automatic longint saturate(input longint value, input int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (value > hi) return hi;
      if (value < -hi - 1) return -hi - 1;
      return value;
   endfunction

   // Cosine and sine of a 32-bit binary angle in Q30, by iterative rotation.
   function automatic void unit_vector(input logic [31:0] angle, output longint cos_q30,
                                       output longint sin_q30);
      longint z;
      longint xv;
      longint yv;
      longint dx;
      longint dy;
      int     i;
      z  = longint'($signed(angle));
      xv = longint'(upi_pkg::CORDIC_K_Q30);
      yv = 0;
      // Angles outside +-pi/2 are turned by pi first, with the start vector negated.
      if (z >= (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
         z  = longint'($signed(angle + 32'h8000_0000));
         xv = -xv;
      end
      for (i = 0; i < upi_pkg::CORDIC_STEPS && i < upi_pkg::ATAN_DEPTH; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (z >= 0) begin
            xv -= dx;
            yv += dy;
            z  -= longint'(upi_pkg::ATAN_TURN32[i]);
         end else begin
            xv += dx;
            yv -= dy;
            z  += longint'(upi_pkg::ATAN_TURN32[i]);
         end
      end
      cos_q30 = xv;
      sin_q30 = yv;
   endfunction

   // One Euler step: turn first, then move along the new heading.
   function automatic pose_type advance_pose(input logic signed [15:0] lin,
                                             input logic signed [15:0] ang);
      longint      t;
      longint      delta;
      longint      travel;
      longint      c;
      longint      s;
      logic [31:0] angle32;
      pose_type    pose;
      t         = longint'(period_q);
      delta     = (longint'(ang) * t * longint'(upi_pkg::INV_PI_Q32)
                   + longint'(upi_pkg::HEAD_ROUND)) >>> upi_pkg::HEAD_SHIFT;
      heading_q = heading_q + upi_pkg::ANGLE_BITS'(delta);
      angle32   = 32'(heading_q) << (32 - upi_pkg::ANGLE_BITS);
      unit_vector(angle32, c, s);
      travel = longint'(lin) * t;
      x_q  = saturate(x_q + ((travel * c + longint'(upi_pkg::POS_ROUND))
                             >>> upi_pkg::POS_SHIFT), upi_pkg::POS_BITS);
      y_q  = saturate(y_q + ((travel * s + longint'(upi_pkg::POS_ROUND))
                             >>> upi_pkg::POS_SHIFT), upi_pkg::POS_BITS);
      pose.pos_x   = 32'(saturate(x_q, 32));
      pose.pos_y   = 32'(saturate(y_q, 32));
      pose.heading = angle32[31:16];
      return pose;
   endfunction

   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         pending_poses.delete();
         period_q  = upi_pkg::TICK_PERIOD_RESET;
         heading_q = '0;
         x_q       = 0;
         y_q       = 0;
         failures  = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            period_q = csr_mon.tick_period;
         end
         // Poses are checked before this edge's command is predicted, so a stray
         // pose cannot be matched against a command taken in the same cycle.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_poses.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("%0t: pose transaction with no command pending: x=%0d y=%0d h=%0d",
                           $realtime, rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.heading);
               end
            end else begin
               want = pending_poses.pop_front();
               if (want.pos_x !== rsp_mon.pos_x || want.pos_y !== rsp_mon.pos_y ||
                   want.heading !== rsp_mon.heading) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("%0t: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                              $realtime, want.pos_x, want.pos_y, want.heading,
                              rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.heading);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_poses.push_back(advance_pose(req_mon.linear_speed, req_mon.angular_speed));
         end
      end
      outstanding = pending_poses.size();
   end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Pose integrator testbench
// Drives velocity commands and tick period writes into the pose integrator,
// with random idle bursts on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The slowest run is roughly 1100 commands, each with its own processing time
   // plus at worst a sender gap and a receiver stall. The limit below is several
   // times that.
   localparam int CYCLE_LIMIT  = 400000;
   // Latency of one command, with margin, used for the quiet time at the end.
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_PHASE = 95;
   localparam int STRAIGHT_RUN = 420;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycle_count;
   int   gap_odds;   // one chance in gap_odds of an idle burst before a command, 0 = none
   bit   calm;       // set for the final stretch, where neither side idles

   upi_req_if req_chan ();
   upi_rsp_if rsp_chan ();
   upi_csr_if csr_chan ();

   unicycle_pose_integrator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   upi_pose_checker pose_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_mon     (csr_chan),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The cycle counter ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // The pose receiver alternates between stretches of acceptance and stall
   // bursts. Now and then a long stretch goes by without any stall. Once the
   // final stretch begins it stays ready for good.
   initial begin : pose_receiver
      int run_len;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 16);
         rsp_chan.ready = 1'b1;
         repeat (run_len) @(negedge clock);
         if (!calm) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
      end
   end

   // Presents one velocity command and returns at the falling edge after it has
   // been accepted. Valid is left high so that a following command can go out
   // back to back; park_commands lowers it when the sender steps aside.
   task automatic send_velocity(input logic signed [15:0] lin,
                                input logic signed [15:0] ang);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.linear_speed  = lin;
      req_chan.angular_speed = ang;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic park_commands();
      req_chan.valid = 1'b0;
   endtask

   // Holds the sender until every predicted pose has come back, which also means
   // the block has gone idle, since each command yields exactly one pose.
   task automatic drain_commands();
      park_commands();
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   // Writes the tick period once the block is idle.
   task automatic write_tick_period(input logic [15:0] period);
      drain_commands();
      csr_chan.valid       = 1'b1;
      csr_chan.tick_period = period;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // A speed or turn rate: the rails, small values around zero, or any pattern.
   function automatic logic signed [15:0] pick_rate();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] periods [7];
      int          p;
      int          n;

      // Every input is at a known value from time zero.
      req_chan.valid         = 1'b0;
      req_chan.linear_speed  = '0;
      req_chan.angular_speed = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.tick_period   = '0;
      calm                   = 1'b0;
      gap_odds               = 3;
      reset                  = 1'b1;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset tick period: rails of both fields, each
      // combination of signs at full scale, and the smallest nonzero steps.
      send_velocity(16'sd0, 16'sd0);
      send_velocity(16'sh7FFF, 16'sd0);
      send_velocity(16'sh8000, 16'sd0);
      send_velocity(16'sd0, 16'sh7FFF);
      send_velocity(16'sd0, 16'sh8000);
      send_velocity(16'sh7FFF, 16'sh7FFF);
      send_velocity(16'sh8000, 16'sh8000);
      send_velocity(16'sh7FFF, 16'sh8000);
      send_velocity(16'sh8000, 16'sh7FFF);
      send_velocity(16'sd1, 16'sd1);
      send_velocity(-16'sd1, -16'sd1);

      // With a zero tick period nothing moves, and each pose repeats the last one.
      write_tick_period(16'd0);
      send_velocity(16'sh7FFF, 16'sh7FFF);
      send_velocity(16'sh8000, 16'sh8000);

      // A one second tick and a turn rate near pi/2 rad/s step the heading about a
      // quarter turn per command, so it passes through every quadrant, across the
      // pi/2 folds of the rotation and across the wrap at pi.
      write_tick_period(16'hFFFF);
      for (n = 0; n < 10; n++) begin
         send_velocity(16'sh7FFF, 16'sd6434);
      end

      // The shortest nonzero tick.
      write_tick_period(16'd1);
      send_velocity(16'sh7FFF, 16'sh7FFF);
      send_velocity(16'sh8000, 16'sh8000);

      // Random part: one phase per tick period, the extremes among them.
      periods = '{16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1, 16'd0,
                  upi_pkg::TICK_PERIOD_RESET, 16'($urandom_range(1, 64)), 16'($urandom)};
      for (p = 0; p < 7; p++) begin
         write_tick_period(periods[p]);
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
         // The final phase runs with no idling on either side.
         calm = (p == 6);
         if (p == 0) begin
            // Driving straight at full speed with a one second tick moves about
            // 128 m per command, which runs at least one coordinate into its rail.
            for (n = 0; n < STRAIGHT_RUN; n++) begin
               send_velocity(16'sh7FFF, 16'sd0);
            end
         end
         for (n = 0; n < RANDOM_PHASE; n++) begin
            // Once in the middle of a phase the sender waits for every pose.
            if (p == 2 && n == RANDOM_PHASE / 2) begin
               drain_commands();
            end
            send_velocity(pick_rate(), pick_rate());
         end
      end

      // Let every pose come back, then leave time for anything stray to show up.
      park_commands();
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
